// ----- sv/fft8_pkg.sv -----
// shared types, constants and index functions for the eight-point fft
`default_nettype none

package fft8_pkg;

    // default parameter values
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TWIDDLE_FRAC_DEF = 15;

    // frame and memory geometry
    localparam int FRAME_LEN  = 8;
    localparam int IDX_W      = 3;
    localparam int BANK_DEPTH = 4;
    localparam int BANK_AW    = 2;

    // result item layout
    localparam int BIN_W      = 20;
    localparam int M_TDATA_W  = 48;
    localparam int TDATA_PAD  = M_TDATA_W - 2 * BIN_W - IDX_W;

    // sqrt(1/2) in 0.32 fixed point
    localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;

    // twiddle applied on the lower leg of a butterfly
    typedef enum logic [1:0] {
        TW_ONE   = 2'd0,
        TW_W1    = 2'd1,
        TW_NEG_J = 2'd2,
        TW_W3    = 2'd3
    } tw_t;

    // control that travels with one butterfly through the pipeline
    typedef struct packed {
        logic             vld;
        logic             frm;
        logic [IDX_W-1:0] top_addr;
        logic [IDX_W-1:0] bot_addr;
        tw_t              tw;
    } bfly_ctl_t;

    // round(sqrt(1/2) * 2^frac)
    function automatic logic [63:0] twiddle_c(input int unsigned frac);
        logic [63:0] half;
        half = 64'd1 << (31 - frac);
        return (SQRT_HALF_Q32 + half) >> (32 - frac);
    endfunction

    // three-bit bit reversal
    function automatic logic [IDX_W-1:0] bitrev3(input logic [IDX_W-1:0] i);
        return {i[0], i[1], i[2]};
    endfunction

    // upper leg index of butterfly n in stage s
    function automatic logic [IDX_W-1:0] top_index(input logic [1:0] s,
                                                   input logic [1:0] n);
        logic [IDX_W-1:0] idx;
        case (s)
            2'd0: idx = {n, 1'b0};
            2'd1: idx = {n[1], 1'b0, n[0]};
            default: idx = {1'b0, n};
        endcase
        return idx;
    endfunction

    // twiddle for the butterfly whose upper leg is top in stage s
    function automatic tw_t tw_sel(input logic [1:0] s, input logic [IDX_W-1:0] top);
        tw_t tw;
        case (s)
            2'd0: tw = TW_ONE;
            2'd1: tw = top[0] ? TW_NEG_J : TW_ONE;
            default: begin
                case (top[1:0])
                    2'd0: tw = TW_ONE;
                    2'd1: tw = TW_W1;
                    2'd2: tw = TW_NEG_J;
                    default: tw = TW_W3;
                endcase
            end
        endcase
        return tw;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fft8_frame_mem.sv -----
// sample frame memory: one write port, two registered read ports
`default_nettype none

module fft8_frame_mem import fft8_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [IDX_W-1:0]               waddr,
    input  wire logic signed [SAMPLE_WIDTH-1:0] wdata,
    input  wire logic [IDX_W-1:0]               raddr0,
    input  wire logic [IDX_W-1:0]               raddr1,
    output logic signed [SAMPLE_WIDTH-1:0]      rdata0,
    output logic signed [SAMPLE_WIDTH-1:0]      rdata1
);

    logic signed [SAMPLE_WIDTH-1:0] mem_reg [FRAME_LEN];
    logic signed [SAMPLE_WIDTH-1:0] rdata0_reg;
    logic signed [SAMPLE_WIDTH-1:0] rdata1_reg;

    // sample write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        rdata0_reg <= mem_reg[raddr0];
        rdata1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ----- sv/fft8_work_bank.sv -----
// one bank of the complex work memory: one write, one registered read
`default_nettype none

module fft8_work_bank import fft8_pkg::*; #(
    parameter int DATA_W = 2 * (SAMPLE_WIDTH_DEF + 4)
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [BANK_AW-1:0] waddr,
    input  wire logic [DATA_W-1:0]  wdata,
    input  wire logic [BANK_AW-1:0] raddr,
    output logic [DATA_W-1:0]       rdata
);

    logic [DATA_W-1:0] mem_reg [BANK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/fft8_bfly.sv -----
// radix-2 butterfly: twiddle multiply and round, register, then add and subtract
`default_nettype none

module fft8_bfly import fft8_pkg::*; #(
    parameter int ACC_W             = SAMPLE_WIDTH_DEF + 4,
    parameter int TWIDDLE_FRAC_BITS = TWIDDLE_FRAC_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire bfly_ctl_t               ctl_in,
    input  wire logic signed [ACC_W-1:0] a_re,
    input  wire logic signed [ACC_W-1:0] a_im,
    input  wire logic signed [ACC_W-1:0] b_re,
    input  wire logic signed [ACC_W-1:0] b_im,
    output bfly_ctl_t                    ctl_out,
    output logic signed [ACC_W-1:0]      x0_re,
    output logic signed [ACC_W-1:0]      x0_im,
    output logic signed [ACC_W-1:0]      x1_re,
    output logic signed [ACC_W-1:0]      x1_im
);

    localparam int CW = TWIDDLE_FRAC_BITS + 1;
    localparam int SW = ACC_W + 1;
    localparam int PW = SW + CW;
    localparam logic signed [CW-1:0] TW_C = CW'(twiddle_c(TWIDDLE_FRAC_BITS));
    localparam logic signed [PW-1:0] RND  = PW'(1) << (TWIDDLE_FRAC_BITS - 1);

    logic signed [SW-1:0]    sum_p;
    logic signed [SW-1:0]    sum_m;
    logic signed [PW-1:0]    prod_p;
    logic signed [PW-1:0]    prod_m;
    logic signed [PW-1:0]    biased_p;
    logic signed [PW-1:0]    biased_m;
    logic signed [ACC_W-1:0] rnd_p;
    logic signed [ACC_W-1:0] rnd_m;
    logic signed [ACC_W-1:0] t_re;
    logic signed [ACC_W-1:0] t_im;

    bfly_ctl_t               ctl_reg;
    logic signed [ACC_W-1:0] a_re_reg;
    logic signed [ACC_W-1:0] a_im_reg;
    logic signed [ACC_W-1:0] t_re_reg;
    logic signed [ACC_W-1:0] t_im_reg;

    // scaled sums for the odd eighth-turn twiddles
    assign sum_p    = SW'(b_re) + SW'(b_im);
    assign sum_m    = SW'(b_im) - SW'(b_re);
    assign prod_p   = sum_p * TW_C;
    assign prod_m   = sum_m * TW_C;
    assign biased_p = prod_p + RND;
    assign biased_m = prod_m + RND;
    assign rnd_p    = ACC_W'(biased_p >>> TWIDDLE_FRAC_BITS);
    assign rnd_m    = ACC_W'(biased_m >>> TWIDDLE_FRAC_BITS);

    // twiddle select
    always_comb begin
        case (ctl_in.tw)
            TW_ONE: begin
                t_re = b_re;
                t_im = b_im;
            end
            TW_W1: begin
                t_re = rnd_p;
                t_im = rnd_m;
            end
            TW_NEG_J: begin
                t_re = b_im;
                t_im = -b_re;
            end
            default: begin
                t_re = rnd_m;
                t_im = -rnd_p;
            end
        endcase
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    // operand register
    always_ff @(posedge aclk) begin
        a_re_reg <= a_re;
        a_im_reg <= a_im;
        t_re_reg <= t_re;
        t_im_reg <= t_im;
    end

    // sum and difference legs
    assign ctl_out = ctl_reg;
    assign x0_re   = a_re_reg + t_re_reg;
    assign x0_im   = a_im_reg + t_im_reg;
    assign x1_re   = a_re_reg - t_re_reg;
    assign x1_im   = a_im_reg - t_im_reg;

endmodule

`default_nettype wire

// ----- sv/fft_8_point_radix2.sv -----
// eight-point radix-2 dit fft on a stream of real samples, bins in natural order
// bins follow once the butterfly stages of a frame are done; each bin is read from the
//   work memory, then loaded into the output register, and a new bin read waits for the
//   previous one to load and for a free output register; frame rate, when the next frame
//   is waiting, is set by one butterfly issue per cycle on the banked work memory, a drain
//   state after each stage and the read-then-load path of the output register
// reset: synchronous active low; clears the sample count, sequencer and valid flags
`default_nettype none

module fft_8_point_radix2 import fft8_pkg::*; #(
    parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_FRAC_BITS = TWIDDLE_FRAC_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // sample_real
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // bin_real, bin_imag, bin_index, zero pad
    output logic [M_TDATA_W-1:0]                         m_tdata,
    // last_bin
    output logic                                         m_tlast
);

    localparam int ACC_W = SAMPLE_WIDTH + 4;
    localparam int CPX_W = 2 * ACC_W;

    typedef enum logic [3:0] {
        ST_FILL  = 4'b0001,
        ST_BFLY  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       stage_reg, stage_next;
    logic [1:0]       bf_reg, bf_next;
    logic             drain_reg, drain_next;
    logic [IDX_W-1:0] bin_reg, bin_next;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             m_valid_reg;
    bfly_ctl_t        ctl_reg;

    logic signed [BIN_W-1:0] m_re_reg;
    logic signed [BIN_W-1:0] m_im_reg;
    logic [IDX_W-1:0]        m_idx_reg;

    logic                           s_accept;
    logic                           issue_out;
    logic [IDX_W-1:0]               top_w;
    logic [IDX_W-1:0]               bot_w;
    bfly_ctl_t                      issue_ctl;
    logic signed [SAMPLE_WIDTH-1:0] sample_w;
    logic signed [SAMPLE_WIDTH-1:0] fm_rd0;
    logic signed [SAMPLE_WIDTH-1:0] fm_rd1;

    logic [BANK_AW-1:0] b0_raddr, b1_raddr, b0_waddr, b1_waddr;
    logic [CPX_W-1:0]   b0_rd, b1_rd, b0_wd, b1_wd;
    logic [CPX_W-1:0]   a_pack, b_pack, out_pack;

    logic signed [ACC_W-1:0] a_re, a_im, b_re, b_im;
    bfly_ctl_t               wb_ctl;
    logic signed [ACC_W-1:0] x0_re, x0_im, x1_re, x1_im;
    logic                    wb_top_bank;

    // input handshake: hold off while stage one reads the frame, and on the
    // eighth sample of the next frame until the current one has left
    assign s_tready = !(state_reg == ST_BFLY && stage_reg == 2'd0)
                      && (state_reg == ST_FILL || cnt_reg != 3'd7);
    assign s_accept = s_tvalid && s_tready;
    assign sample_w = s_tdata[SAMPLE_WIDTH-1:0];

    // butterfly issue
    assign top_w = top_index(stage_reg, bf_reg);
    assign bot_w = top_w | (3'd1 << stage_reg);

    always_comb begin
        issue_ctl.vld      = (state_reg == ST_BFLY);
        issue_ctl.frm      = (stage_reg == 2'd0);
        issue_ctl.top_addr = top_w;
        issue_ctl.bot_addr = bot_w;
        issue_ctl.tw       = tw_sel(stage_reg, top_w);
    end

    // output read issue: the output register is free by the time data lands
    assign issue_out = (state_reg == ST_OUT) && !pend_reg && (!m_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        drain_next = drain_reg;
        bin_next   = bin_reg;
        if (s_accept) begin
            cnt_next = cnt_reg + 3'd1;
        end
        case (state_reg)
            ST_FILL: begin
                if (s_accept && cnt_reg == 3'd7) begin
                    state_next = ST_BFLY;
                    stage_next = 2'd0;
                    bf_next    = 2'd0;
                end
            end
            ST_BFLY: begin
                bf_next = bf_reg + 2'd1;
                if (bf_reg == 2'd3) begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    if (stage_reg == 2'd2) begin
                        state_next = ST_OUT;
                        bin_next   = '0;
                    end else begin
                        state_next = ST_BFLY;
                        stage_next = stage_reg + 2'd1;
                        bf_next    = 2'd0;
                    end
                end
            end
            ST_OUT: begin
                if (issue_out) begin
                    bin_next = bin_reg + 3'd1;
                    if (bin_reg == 3'd7) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            cnt_reg      <= '0;
            stage_reg    <= '0;
            bf_reg       <= '0;
            drain_reg    <= 1'b0;
            bin_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            ctl_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            stage_reg    <= stage_next;
            bf_reg       <= bf_next;
            drain_reg    <= drain_next;
            bin_reg      <= bin_next;
            pend_reg     <= issue_out;
            pend_idx_reg <= bin_reg;
            ctl_reg      <= issue_ctl;
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // frame buffer
    fft8_frame_mem #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_frame (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (cnt_reg),
        .wdata (sample_w),
        .raddr0(bitrev3(top_w)),
        .raddr1(bitrev3(bot_w)),
        .rdata0(fm_rd0),
        .rdata1(fm_rd1)
    );

    // work memory banked on index parity, so both legs of a butterfly hit
    // different banks
    always_comb begin
        if (state_reg == ST_OUT) begin
            b0_raddr = bin_reg[2:1];
            b1_raddr = bin_reg[2:1];
        end else if (^top_w) begin
            b0_raddr = bot_w[2:1];
            b1_raddr = top_w[2:1];
        end else begin
            b0_raddr = top_w[2:1];
            b1_raddr = bot_w[2:1];
        end
    end

    // write-back routing
    assign wb_top_bank = ^wb_ctl.top_addr;
    assign b0_waddr = wb_top_bank ? wb_ctl.bot_addr[2:1] : wb_ctl.top_addr[2:1];
    assign b1_waddr = wb_top_bank ? wb_ctl.top_addr[2:1] : wb_ctl.bot_addr[2:1];
    assign b0_wd    = wb_top_bank ? {x1_im, x1_re} : {x0_im, x0_re};
    assign b1_wd    = wb_top_bank ? {x0_im, x0_re} : {x1_im, x1_re};

    fft8_work_bank #(
        .DATA_W(CPX_W)
    ) u_bank0 (
        .aclk (aclk),
        .we   (wb_ctl.vld),
        .waddr(b0_waddr),
        .wdata(b0_wd),
        .raddr(b0_raddr),
        .rdata(b0_rd)
    );

    fft8_work_bank #(
        .DATA_W(CPX_W)
    ) u_bank1 (
        .aclk (aclk),
        .we   (wb_ctl.vld),
        .waddr(b1_waddr),
        .wdata(b1_wd),
        .raddr(b1_raddr),
        .rdata(b1_rd)
    );

    // operand select: real samples in stage one, work memory afterwards
    assign a_pack = (^ctl_reg.top_addr) ? b1_rd : b0_rd;
    assign b_pack = (^ctl_reg.top_addr) ? b0_rd : b1_rd;

    always_comb begin
        if (ctl_reg.frm) begin
            a_re = ACC_W'(fm_rd0);
            a_im = '0;
            b_re = ACC_W'(fm_rd1);
            b_im = '0;
        end else begin
            a_re = signed'(a_pack[ACC_W-1:0]);
            a_im = signed'(a_pack[CPX_W-1:ACC_W]);
            b_re = signed'(b_pack[ACC_W-1:0]);
            b_im = signed'(b_pack[CPX_W-1:ACC_W]);
        end
    end

    fft8_bfly #(
        .ACC_W            (ACC_W),
        .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
    ) u_bfly (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl_in (ctl_reg),
        .a_re   (a_re),
        .a_im   (a_im),
        .b_re   (b_re),
        .b_im   (b_im),
        .ctl_out(wb_ctl),
        .x0_re  (x0_re),
        .x0_im  (x0_im),
        .x1_re  (x1_re),
        .x1_im  (x1_im)
    );

    // output register load
    assign out_pack = pend_idx_reg[0] ^ pend_idx_reg[1] ^ pend_idx_reg[2] ? b1_rd : b0_rd;

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            m_re_reg  <= BIN_W'(signed'(out_pack[ACC_W-1:0]));
            m_im_reg  <= BIN_W'(signed'(out_pack[CPX_W-1:ACC_W]));
            m_idx_reg <= pend_idx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{TDATA_PAD{1'b0}}, m_idx_reg, m_im_reg, m_re_reg};
    assign m_tlast  = (m_idx_reg == 3'd7);

endmodule

`default_nettype wire
